// ----- rtl/core/csvsel_pkg.sv -----
// Shared types and constants of the CSV column selector.
`timescale 1ns / 1ps

package csvsel_pkg;

  // Fixed characters of the line format.
  localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
  localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;

  // Reset values of the configuration registers.
  localparam logic [7:0]  DELIMITER_RESET    = 8'd44;
  localparam logic [7:0]  QUOTE_CHAR_RESET   = 8'd34;
  localparam logic [63:0] FIELD_SELECT_RESET = 64'd1;

  // Width of the selection mask, one bit for each field.
  localparam int unsigned SELECT_WIDTH = 64;
  localparam int unsigned SELECT_IDX_W = 6;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELIMITER    = 2'd0,
    REG_QUOTE_CHAR   = 2'd1,
    REG_FIELD_SELECT = 2'd2
  } reg_index_t;

  // Output queue geometry.
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = 2;
  localparam int unsigned OUTQ_CNT_W = 3;

  // One result item.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } out_item_t;

  // Write request into the output queue: zero, one or two items.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } outq_write_t;

endpackage

// ----- rtl/core/csvsel_out_queue.sv -----
// Four-entry output queue that takes up to two items per cycle and gives one while m_tready is high.
`timescale 1ns / 1ps

module csvsel_out_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  csvsel_pkg::outq_write_t wr,
  output logic                    room_for_two,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output csvsel_pkg::out_item_t   head
);
  import csvsel_pkg::*;

  out_item_t             mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic                  pop;

  assign m_tvalid     = (count != '0);
  assign head         = mem[rd_ptr];
  assign pop          = m_tvalid && m_tready;
  assign room_for_two = (count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(wr.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      count <= count + OUTQ_CNT_W'(wr.count) - OUTQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      mem[wr_ptr + OUTQ_PTR_W'(1)] <= wr.second;
    end
  end

endmodule

// ----- rtl/core/csv_column_selector_core.sv -----
// Top level of the CSV column selector: field tracking and output queue.
`timescale 1ns / 1ps

// Channel   | Direction | Signals                              | Carries
// ----------+-----------+--------------------------------------+------------------------------
// s_*       | in        | s_tvalid s_tready s_tdata s_tlast    | one text byte, line end flag
// m_*       | out       | m_tvalid m_tready m_tdata m_tlast    | one selected byte, line end
// cfg_*     | in        | cfg_valid cfg_ready cfg_index        | register writes, always taken
//           |           | cfg_data                             |
//
// A transfer on s_* updates the field count, quote state and held byte, and its results
// enter a four-entry output queue that m_* drains one transfer per cycle while m_tready
// is high; a new byte can be taken before the earlier results leave the queue.
// s_tready drops while the queue has fewer than two free entries; since a line never yields
// more results than it has bytes, this happens only when m_tready stalls.
// Reset (rst, synchronous) empties the queue, clears line state and restores the defaults.

module csv_column_selector_core #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input bytes. s_tdata: [7:0] in_byte. s_tlast: line_end.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,
  input  logic                              s_tlast,
  // Output bytes. m_tdata: [7:0] out_byte. m_tlast: out_last.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast,
  // Configuration writes: index 0 delimiter, 1 quote_char, 2 field_select.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csvsel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                       cfg_data
);
  import csvsel_pkg::*;

  // The field count saturates at MAX_FIELDS, so it needs room for that value.
  localparam int unsigned FIELD_W = $clog2(MAX_FIELDS + 1);
  localparam logic [FIELD_W-1:0] FIELD_LIMIT = FIELD_W'(MAX_FIELDS);

  // Configuration registers.
  logic [7:0]              delimiter;
  logic [7:0]              quote_char;
  logic [SELECT_WIDTH-1:0] field_select;

  // Line state.
  logic [FIELD_W-1:0] field_number;
  logic               inside_quotes;
  logic [7:0]         previous_byte;
  logic [7:0]         held_byte;
  logic               held_valid;

  logic [FIELD_W-1:0] field_number_next;
  logic               inside_quotes_next;
  logic [7:0]         held_byte_next;
  logic               held_valid_next;

  logic                    accept;
  logic                    room_for_two;
  logic [SELECT_IDX_W-1:0] select_idx;
  logic                    field_chosen;
  logic                    is_quote;
  logic                    is_delim;
  outq_write_t             wr;
  out_item_t               head;

  assign cfg_ready = 1'b1;

  // Configuration writes are to be made only while the stream is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter    <= DELIMITER_RESET;
      quote_char   <= QUOTE_CHAR_RESET;
      field_select <= FIELD_SELECT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER:    delimiter    <= cfg_data[7:0];
        REG_QUOTE_CHAR:   quote_char   <= cfg_data[7:0];
        REG_FIELD_SELECT: field_select <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign s_tready = room_for_two;
  assign accept   = s_tvalid && s_tready;

  // A field is chosen by its mask bit, as long as the count has not saturated.
  assign select_idx   = SELECT_IDX_W'(field_number);
  assign field_chosen = (field_number < FIELD_LIMIT) && field_select[select_idx];

  // A quote byte wins over the delimiter when both are set to the same value.
  assign is_quote = (s_tdata == quote_char);
  assign is_delim = !is_quote && (s_tdata == delimiter);

  always_comb begin
    field_number_next  = field_number;
    inside_quotes_next = inside_quotes;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;

    if (is_quote && previous_byte != BACKSLASH_BYTE) begin
      inside_quotes_next = !inside_quotes;
    end
    if (is_delim && !inside_quotes && field_number < FIELD_LIMIT) begin
      field_number_next = field_number + FIELD_W'(1);
    end
    if (field_chosen) begin
      held_byte_next  = s_tdata;
      held_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number  <= '0;
      inside_quotes <= 1'b0;
      previous_byte <= '0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
    end else if (accept) begin
      held_byte <= held_byte_next;
      if (s_tlast) begin
        field_number  <= '0;
        inside_quotes <= 1'b0;
        previous_byte <= '0;
        held_valid    <= 1'b0;
      end else begin
        field_number  <= field_number_next;
        inside_quotes <= inside_quotes_next;
        previous_byte <= s_tdata;
        held_valid    <= held_valid_next;
      end
    end
  end

  // The held byte goes out when a newer chosen byte displaces it. At line end the
  // last byte becomes a newline, sent alone unless a chosen last byte displaces a held one.
  always_comb begin
    wr.first.data  = held_byte;
    wr.first.last  = 1'b0;
    wr.second.data = NEWLINE_BYTE;
    wr.second.last = 1'b1;
    wr.count       = 2'd0;
    if (accept) begin
      if (field_chosen && held_valid) begin
        wr.count = s_tlast ? 2'd2 : 2'd1;
      end else if (s_tlast) begin
        wr.count       = 2'd1;
        wr.first.data  = NEWLINE_BYTE;
        wr.first.last  = 1'b1;
      end
    end
  end

  csvsel_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .room_for_two (room_for_two),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .head         (head)
  );

  assign m_tdata = head.data;
  assign m_tlast = head.last;

endmodule

// ----- rtl/core/csvsel_checker.sv -----
// Port-level checks of the CSV column selector and their binding.
`timescale 1ns / 1ps

module csvsel_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import csvsel_pkg::*;

  // Reset leaves nothing to send.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Every line ends in a newline.
  a_last_is_newline: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == NEWLINE_BYTE))
    else $error("last byte of a line is not a newline");

  // A line end on the input always yields output on the next cycle.
  a_line_end_output: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("no output after a line end transfer");

  // A stalled output transfer holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed while stalled");

endmodule

bind csv_column_selector_core csvsel_checker u_csvsel_checker (.*);
